// ===== design/sfvms_pkg.sv =====
`timescale 1ns / 1ps
// Package: sizes, frame codes and the control/status types of the frame server.
package sfvms_pkg;

    localparam int MEM_ADDR_BITS  = 12;
    localparam int MAX_READ_WORDS = 28;
    localparam int CHANNELS       = 2;
    localparam int CH_SLOTS       = 2;
    localparam int MEM_WORDS      = 1 << MEM_ADDR_BITS;
    localparam int CNT_W          = $clog2(MAX_READ_WORDS + 1);

    localparam logic [7:0] HDR_HI       = 8'h5A;
    localparam logic [7:0] HDR_LO       = 8'hA5;
    localparam logic [7:0] CMD_WRITE    = 8'h82;
    localparam logic [7:0] CMD_READ     = 8'h83;
    localparam logic [7:0] ACK_HI       = 8'h4F;
    localparam logic [7:0] ACK_LO       = 8'h4B;
    localparam logic [7:0] WR_REPLY_LEN = 8'h03;

    typedef struct packed {
        logic in_ready;
        logic clear;
        logic parse;
        logic load_hdr;
        logic rd_issue;
        logic load_hi;
        logic load_lo;
    } sfvms_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic clr_done;
        logic fin_write;
        logic fin_read;
        logic hdr_last;
        logic no_words;
        logic word_last;
        logic out_free;
    } sfvms_sts_t;

endpackage

// ===== design/sfvms_if.sv =====
`timescale 1ns / 1ps
// Interfaces: received-byte channel and reply-byte channel.
interface sfvms_in_if;
    logic       valid;
    logic       ready;
    logic       in_channel;
    logic [7:0] rx_byte;

    modport source (output valid, output in_channel, output rx_byte, input ready);
    modport sink   (input valid, input in_channel, input rx_byte, output ready);
endinterface

interface sfvms_out_if;
    logic       valid;
    logic       ready;
    logic       out_channel;
    logic [7:0] tx_byte;
    logic       last_of_reply;

    modport source (output valid, output out_channel, output tx_byte, output last_of_reply,
                    input ready);
    modport sink   (input valid, input out_channel, input tx_byte, input last_of_reply,
                    output ready);
endinterface

// ===== design/serial_frame_variable_memory_server.sv =====
`timescale 1ns / 1ps
// A received item is latched in ST_IDLE and parsed in ST_PARSE; rx.ready returns in ST_IDLE
// when the item ends no frame.
// A frame end is followed by its reply: header bytes in ST_HDR, then for each read word
// ST_RD_ISSUE, ST_HI and ST_LO (one memory read port, one read per reply word); tx stalls hold it.
// Reset: async active low; a clearing pass over all 2^MEM_ADDR_BITS (4096) words zeroes the
// variable memory with rx.ready held low.
module serial_frame_variable_memory_server (
    input  logic        clk,
    input  logic        rst_n,
    sfvms_in_if.sink    rx,
    sfvms_out_if.source tx
);
    import sfvms_pkg::*;

    sfvms_cmd_t cmd;
    sfvms_sts_t sts;

    sfvms_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    sfvms_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .rx    (rx),
        .tx    (tx)
    );

endmodule

// ===== design/sfvms_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences memory clear, byte parsing and reply streaming.
module sfvms_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sfvms_pkg::sfvms_sts_t  sts,
    output sfvms_pkg::sfvms_cmd_t  cmd
);
    import sfvms_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PARSE,
        ST_HDR,
        ST_RD_ISSUE,
        ST_HI,
        ST_LO
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    state_next = ST_PARSE;
                end
            end
            ST_PARSE:
            begin
                cmd.parse = 1'b1;
                if (sts.fin_write || sts.fin_read)
                begin
                    state_next = ST_HDR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_HDR:
            begin
                if (sts.out_free)
                begin
                    cmd.load_hdr = 1'b1;
                    if (sts.hdr_last)
                    begin
                        state_next = sts.no_words ? ST_IDLE : ST_RD_ISSUE;
                    end
                end
            end
            ST_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_HI;
            end
            ST_HI:
            begin
                if (sts.out_free)
                begin
                    cmd.load_hi = 1'b1;
                    state_next  = ST_LO;
                end
            end
            ST_LO:
            begin
                if (sts.out_free)
                begin
                    cmd.load_lo = 1'b1;
                    state_next  = sts.word_last ? ST_IDLE : ST_RD_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/sfvms_dp.sv =====
`timescale 1ns / 1ps
// Datapath: per-channel parsers, variable memory, reply counters and output register.
module sfvms_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sfvms_pkg::sfvms_cmd_t  cmd,
    output sfvms_pkg::sfvms_sts_t  sts,
    sfvms_in_if.sink               rx,
    sfvms_out_if.source            tx
);
    import sfvms_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_GOT5A,
        PH_GOTHDR,
        PH_GOTLEN,
        PH_BODY
    } phase_t;

    localparam logic [2:0] HDR_LAST_WR = 3'd5;
    localparam logic [2:0] HDR_LAST_RD = 3'd6;

    // latched input item
    logic       ch_reg;
    logic [7:0] byte_reg;

    // per-channel parser state
    phase_t      phase_reg [CH_SLOTS];
    logic [7:0]  len_reg   [CH_SLOTS];
    logic [7:0]  fcmd_reg  [CH_SLOTS];
    logic [7:0]  idx_reg   [CH_SLOTS];
    logic [15:0] addr_reg  [CH_SLOTS];
    logic [7:0]  held_reg  [CH_SLOTS];

    // variable memory
    logic [15:0]              mem [MEM_WORDS];
    logic [15:0]              rdata_reg;
    logic [MEM_ADDR_BITS-1:0] clr_addr_reg;
    logic                     mem_we;
    logic [MEM_ADDR_BITS-1:0] mem_waddr;
    logic [15:0]              mem_wdata;
    logic [MEM_ADDR_BITS-1:0] mem_raddr;

    // reply context
    logic             rep_ch_reg;
    logic             rep_write_reg;
    logic [CNT_W-1:0] rep_cnt_reg;
    logic [15:0]      rep_addr_reg;
    logic [2:0]       hdr_idx_reg;
    logic [CNT_W-1:0] word_idx_reg;

    // output register
    logic       tv_reg;
    logic       tch_reg;
    logic [7:0] tbyte_reg;
    logic       tlast_reg;

    // parse step signals
    logic        ch_ok;
    phase_t      phase_cur;
    logic [7:0]  len_cur;
    logic [7:0]  fcmd_cur;
    logic [7:0]  idx_cur;
    logic [15:0] addr_cur;
    logic [7:0]  held_cur;
    phase_t      phase_nx;
    logic [7:0]  len_nx;
    logic [7:0]  fcmd_nx;
    logic [7:0]  idx_nx;
    logic [15:0] addr_nx;
    logic [7:0]  held_nx;
    logic [7:0]  idx_inc;
    logic        finishing;
    logic        we_parse;
    logic        fin_write;
    logic        fin_read;

    // reply byte selection
    logic [7:0] cnt_byte;
    logic [7:0] rd_len_byte;
    logic [7:0] hdr_byte;
    logic       hdr_last;
    logic       hdr_last_flag;
    logic       word_last;
    logic       out_free;
    logic       load_any;

    assign ch_ok     = (int'(ch_reg) < CHANNELS);
    assign phase_cur = phase_reg[ch_reg];
    assign len_cur   = len_reg[ch_reg];
    assign fcmd_cur  = fcmd_reg[ch_reg];
    assign idx_cur   = idx_reg[ch_reg];
    assign addr_cur  = addr_reg[ch_reg];
    assign held_cur  = held_reg[ch_reg];
    assign idx_inc   = idx_cur + 8'd1;

    always_comb
    begin
        phase_nx  = phase_cur;
        len_nx    = len_cur;
        fcmd_nx   = fcmd_cur;
        idx_nx    = idx_cur;
        addr_nx   = addr_cur;
        held_nx   = held_cur;
        finishing = 1'b0;
        we_parse  = 1'b0;
        unique case (phase_cur)
            PH_GOT5A:
            begin
                if (byte_reg == HDR_LO)
                begin
                    phase_nx = PH_GOTHDR;
                end
                else if (byte_reg != HDR_HI)
                begin
                    phase_nx = PH_HUNT;
                end
            end
            PH_GOTHDR:
            begin
                len_nx   = byte_reg;
                phase_nx = PH_GOTLEN;
            end
            PH_GOTLEN:
            begin
                fcmd_nx = byte_reg;
                if (byte_reg != CMD_WRITE && byte_reg != CMD_READ)
                begin
                    // drop the leading 5A and rescan A5, length, command
                    if (len_cur == HDR_HI && byte_reg == HDR_LO)
                    begin
                        phase_nx = PH_GOTHDR;
                    end
                    else if (byte_reg == HDR_HI)
                    begin
                        phase_nx = PH_GOT5A;
                    end
                    else
                    begin
                        phase_nx = PH_HUNT;
                    end
                end
                else if (len_cur < 8'd3)
                begin
                    phase_nx = PH_HUNT;
                end
                else
                begin
                    idx_nx   = 8'd0;
                    held_nx  = 8'd0;
                    phase_nx = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (idx_cur == 8'd0)
                begin
                    addr_nx = {byte_reg, 8'h00};
                end
                else if (idx_cur == 8'd1)
                begin
                    addr_nx = addr_cur | {8'h00, byte_reg};
                end
                else if (fcmd_cur == CMD_READ)
                begin
                    if (idx_cur == 8'd2)
                    begin
                        held_nx = byte_reg;
                    end
                end
                else if (!idx_cur[0])
                begin
                    held_nx = byte_reg;
                end
                else
                begin
                    we_parse = 1'b1;
                    addr_nx  = addr_cur + 16'd1;
                end
                idx_nx = idx_inc;
                if (({1'b0, idx_inc} + 9'd1) >= {1'b0, len_cur})
                begin
                    finishing = 1'b1;
                    phase_nx  = PH_HUNT;
                end
            end
            default:
            begin
                phase_nx = (byte_reg == HDR_HI) ? PH_GOT5A : PH_HUNT;
            end
        endcase
    end

    assign fin_write = cmd.parse && ch_ok && finishing && (fcmd_cur == CMD_WRITE);
    assign fin_read  = cmd.parse && ch_ok && finishing && (fcmd_cur != CMD_WRITE)
                       && (len_cur >= 8'd4) && (held_nx <= 8'(MAX_READ_WORDS));

    always_ff @(posedge clk)
    begin
        if (cmd.in_ready && rx.valid)
        begin
            ch_reg   <= rx.in_channel;
            byte_reg <= rx.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH_SLOTS; i++)
            begin
                phase_reg[i] <= PH_HUNT;
                len_reg[i]   <= 8'd0;
                fcmd_reg[i]  <= 8'd0;
                idx_reg[i]   <= 8'd0;
                addr_reg[i]  <= 16'd0;
                held_reg[i]  <= 8'd0;
            end
        end
        else if (cmd.parse && ch_ok)
        begin
            phase_reg[ch_reg] <= phase_nx;
            len_reg[ch_reg]   <= len_nx;
            fcmd_reg[ch_reg]  <= fcmd_nx;
            idx_reg[ch_reg]   <= idx_nx;
            addr_reg[ch_reg]  <= addr_nx;
            held_reg[ch_reg]  <= held_nx;
        end
    end

    // memory ports: clear sweep or word write, one read for reply words
    assign mem_we    = cmd.clear || (cmd.parse && ch_ok && we_parse);
    assign mem_waddr = cmd.clear ? clr_addr_reg : addr_cur[MEM_ADDR_BITS-1:0];
    assign mem_wdata = cmd.clear ? 16'd0 : {held_cur, byte_reg};
    assign mem_raddr = rep_addr_reg[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(word_idx_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_issue)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + MEM_ADDR_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_idx_reg  <= 3'd0;
            word_idx_reg <= '0;
        end
        else if (fin_write || fin_read)
        begin
            hdr_idx_reg  <= 3'd0;
            word_idx_reg <= '0;
        end
        else
        begin
            if (cmd.load_hdr)
            begin
                hdr_idx_reg <= hdr_idx_reg + 3'd1;
            end
            if (cmd.load_lo)
            begin
                word_idx_reg <= word_idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_write || fin_read)
        begin
            rep_ch_reg    <= ch_reg;
            rep_write_reg <= fin_write;
            rep_cnt_reg   <= held_nx[CNT_W-1:0];
            rep_addr_reg  <= addr_nx;
        end
    end

    assign cnt_byte    = 8'(rep_cnt_reg);
    assign rd_len_byte = {cnt_byte[6:0], 1'b0} + 8'd4;

    always_comb
    begin
        if (rep_write_reg)
        begin
            unique case (hdr_idx_reg)
                3'd0:    hdr_byte = HDR_HI;
                3'd1:    hdr_byte = HDR_LO;
                3'd2:    hdr_byte = WR_REPLY_LEN;
                3'd3:    hdr_byte = CMD_WRITE;
                3'd4:    hdr_byte = ACK_HI;
                default: hdr_byte = ACK_LO;
            endcase
        end
        else
        begin
            unique case (hdr_idx_reg)
                3'd0:    hdr_byte = HDR_HI;
                3'd1:    hdr_byte = HDR_LO;
                3'd2:    hdr_byte = rd_len_byte;
                3'd3:    hdr_byte = CMD_READ;
                3'd4:    hdr_byte = rep_addr_reg[15:8];
                3'd5:    hdr_byte = rep_addr_reg[7:0];
                default: hdr_byte = cnt_byte;
            endcase
        end
    end

    assign hdr_last      = rep_write_reg ? (hdr_idx_reg == HDR_LAST_WR)
                                         : (hdr_idx_reg == HDR_LAST_RD);
    assign hdr_last_flag = hdr_last && (rep_write_reg || rep_cnt_reg == '0);
    assign word_last     = ({1'b0, word_idx_reg} + (CNT_W + 1)'(1)) == {1'b0, rep_cnt_reg};
    assign out_free      = !tv_reg || tx.ready;
    assign load_any      = cmd.load_hdr || cmd.load_hi || cmd.load_lo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= 1'b0;
        end
        else if (load_any)
        begin
            tv_reg <= 1'b1;
        end
        else if (tx.ready)
        begin
            tv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_any)
        begin
            tch_reg <= rep_ch_reg;
        end
        if (cmd.load_hdr)
        begin
            tbyte_reg <= hdr_byte;
            tlast_reg <= hdr_last_flag;
        end
        else if (cmd.load_hi)
        begin
            tbyte_reg <= rdata_reg[15:8];
            tlast_reg <= 1'b0;
        end
        else if (cmd.load_lo)
        begin
            tbyte_reg <= rdata_reg[7:0];
            tlast_reg <= word_last;
        end
    end

    assign rx.ready         = cmd.in_ready;
    assign tx.valid         = tv_reg;
    assign tx.out_channel   = tch_reg;
    assign tx.tx_byte       = tbyte_reg;
    assign tx.last_of_reply = tlast_reg;

    assign sts.in_valid  = rx.valid;
    assign sts.clr_done  = (clr_addr_reg == MEM_ADDR_BITS'(MEM_WORDS - 1));
    assign sts.fin_write = fin_write;
    assign sts.fin_read  = fin_read;
    assign sts.hdr_last  = hdr_last;
    assign sts.no_words  = rep_write_reg || (rep_cnt_reg == '0);
    assign sts.word_last = word_last;
    assign sts.out_free  = out_free;

    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        load_any |-> out_free)
        else $error("reply byte loaded over an untaken item");

    a_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_issue || cmd.load_hi || cmd.load_lo) |-> (word_idx_reg < rep_cnt_reg))
        else $error("reply word index beyond count");

    a_clear_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.clear |=> $stable(clr_addr_reg))
        else $error("clear address moved outside the clearing pass");

    a_no_input_in_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_hdr || cmd.rd_issue) |-> !rx.ready)
        else $error("input taken while a reply is streaming");

endmodule

// ===== dv/tb_serial_frame_variable_memory_server.sv =====
`timescale 1ns / 1ps
// Testbench: two-channel frame server driven by byte streams and checked against a frame predictor.
module tb_serial_frame_variable_memory_server;
    import sfvms_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int TOTAL_ITEMS    = 460;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_GOT_5A,
        PH_GOT_HDR,
        PH_GOT_LEN,
        PH_BODY
    } parse_phase_t;

    typedef struct packed {
        logic       ch;
        logic [7:0] data;
        logic       last;
    } reply_byte_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sfvms_in_if  rx_if();
    sfvms_out_if tx_if();

    serial_frame_variable_memory_server dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Per-channel parser state and the shared word store, as the block should hold them
    parse_phase_t phase     [CH_SLOTS];
    logic [7:0]   frame_len [CH_SLOTS];
    logic [7:0]   frame_cmd [CH_SLOTS];
    logic [7:0]   body_cnt  [CH_SLOTS];
    logic [15:0]  word_addr [CH_SLOTS];
    logic [7:0]   held_byte [CH_SLOTS];
    logic [15:0]  shadow_mem [MEM_WORDS];

    reply_byte_t reply_bytes_due[$];
    logic [7:0]  ch0_bytes[$];
    logic [7:0]  ch1_bytes[$];

    int   mismatches      = 0;
    int   items_sent      = 0;
    int   replies_checked = 0;
    int   acks_due        = 0;
    int   reads_due       = 0;
    int   frames_dropped  = 0;
    int   idle_cycles     = 0;
    int   send_calm       = 0;
    int   recv_calm       = 0;
    int   hold_left       = 0;
    int   stall_left      = 0;
    bit   send_gaps_on    = 1'b1;
    bit   hold_seen       = 1'b0;
    logic hold_request    = 1'b0;

    function automatic void reset_frame_tracker();
        int i;
        for (i = 0; i < CH_SLOTS; i++)
        begin
            phase[i]     = PH_HUNT;
            frame_len[i] = 8'h00;
            frame_cmd[i] = 8'h00;
            body_cnt[i]  = 8'h00;
            word_addr[i] = 16'h0000;
            held_byte[i] = 8'h00;
        end
        for (i = 0; i < MEM_WORDS; i++)
            shadow_mem[i] = 16'h0000;
    endfunction

    function automatic void push_reply(input logic ch, input logic [7:0] data, input logic last);
        reply_byte_t r;
        r.ch   = ch;
        r.data = data;
        r.last = last;
        reply_bytes_due.push_back(r);
    endfunction

    function automatic void close_frame(input logic ch);
        int                       cnt;
        int                       i;
        logic [MEM_ADDR_BITS-1:0] rd_idx;
        logic [15:0]              w;
        logic [7:0]               reply_len;
        if (frame_cmd[ch] == CMD_WRITE)
        begin
            push_reply(ch, HDR_HI, 1'b0);
            push_reply(ch, HDR_LO, 1'b0);
            push_reply(ch, WR_REPLY_LEN, 1'b0);
            push_reply(ch, CMD_WRITE, 1'b0);
            push_reply(ch, ACK_HI, 1'b0);
            push_reply(ch, ACK_LO, 1'b1);
            acks_due++;
        end
        else if (frame_len[ch] >= 8'd4 && held_byte[ch] <= MAX_READ_WORDS)
        begin
            cnt       = int'(held_byte[ch]);
            reply_len = held_byte[ch] * 8'd2 + 8'd4;
            push_reply(ch, HDR_HI, 1'b0);
            push_reply(ch, HDR_LO, 1'b0);
            push_reply(ch, reply_len, 1'b0);
            push_reply(ch, CMD_READ, 1'b0);
            push_reply(ch, word_addr[ch][15:8], 1'b0);
            push_reply(ch, word_addr[ch][7:0], 1'b0);
            push_reply(ch, held_byte[ch], cnt == 0);
            rd_idx = word_addr[ch][MEM_ADDR_BITS-1:0];
            for (i = 0; i < cnt; i++)
            begin
                w = shadow_mem[rd_idx];
                push_reply(ch, w[15:8], 1'b0);
                push_reply(ch, w[7:0], i + 1 == cnt);
                rd_idx = rd_idx + MEM_ADDR_BITS'(1);
            end
            reads_due++;
        end
        else
            frames_dropped++;
        phase[ch] = PH_HUNT;
    endfunction

    function automatic void take_body_byte(input logic ch, input logic [7:0] b);
        logic [7:0] idx;
        idx = body_cnt[ch];
        if (idx == 8'd0)
            word_addr[ch] = {b, 8'h00};
        else if (idx == 8'd1)
            word_addr[ch] = word_addr[ch] | {8'h00, b};
        else if (frame_cmd[ch] == CMD_READ)
        begin
            // only the count byte matters; later body bytes are padding
            if (idx == 8'd2)
                held_byte[ch] = b;
        end
        else if (idx[0] == 1'b0)
            held_byte[ch] = b;
        else
        begin
            shadow_mem[word_addr[ch][MEM_ADDR_BITS-1:0]] = {held_byte[ch], b};
            word_addr[ch] = word_addr[ch] + 16'd1;
        end
    endfunction

    function automatic void predict_replies(input logic ch, input logic [7:0] b);
        if (int'(ch) >= CHANNELS)
            return;
        case (phase[ch])
            PH_GOT_5A:
            begin
                if (b == HDR_LO)
                    phase[ch] = PH_GOT_HDR;
                else if (b != HDR_HI)
                    phase[ch] = PH_HUNT;
            end
            PH_GOT_HDR:
            begin
                frame_len[ch] = b;
                phase[ch]     = PH_GOT_LEN;
            end
            PH_GOT_LEN:
            begin
                frame_cmd[ch] = b;
                if (b != CMD_WRITE && b != CMD_READ)
                begin
                    // drop the leading 5A and rescan A5 L C
                    if (frame_len[ch] == HDR_HI && b == HDR_LO)
                        phase[ch] = PH_GOT_HDR;
                    else if (b == HDR_HI)
                        phase[ch] = PH_GOT_5A;
                    else
                        phase[ch] = PH_HUNT;
                end
                else if (frame_len[ch] < 8'd3)
                begin
                    phase[ch] = PH_HUNT;
                    frames_dropped++;
                end
                else
                begin
                    body_cnt[ch]  = 8'h00;
                    held_byte[ch] = 8'h00;
                    phase[ch]     = PH_BODY;
                end
            end
            PH_BODY:
            begin
                take_body_byte(ch, b);
                body_cnt[ch] = body_cnt[ch] + 8'd1;
                if ({1'b0, body_cnt[ch]} + 9'd1 >= {1'b0, frame_len[ch]})
                    close_frame(ch);
            end
            default:
                phase[ch] = (b == HDR_HI) ? PH_GOT_5A : PH_HUNT;
        endcase
    endfunction

    // Mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int next_gap(input bit recv_side);
        int r;
        if (recv_side && recv_calm > 0)
        begin
            recv_calm--;
            return 0;
        end
        if (!recv_side && send_calm > 0)
        begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            if (recv_side)
                recv_calm = $urandom_range(20, 60);
            else
                send_calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 16'($urandom_range(0, 47));
        if (r < 75)
            return 16'h0FF0 + 16'($urandom_range(0, 15));
        if (r < 85)
            return 16'hFFF0 + 16'($urandom_range(0, 15));
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic void queue_byte(input logic ch, input logic [7:0] b);
        if (ch)
            ch1_bytes.push_back(b);
        else
            ch0_bytes.push_back(b);
    endfunction

    function automatic void queue_frame_head(input logic ch, input logic [7:0] len,
                                             input logic [7:0] cmd);
        queue_byte(ch, HDR_HI);
        queue_byte(ch, HDR_LO);
        queue_byte(ch, len);
        queue_byte(ch, cmd);
    endfunction

    function automatic void queue_write(input logic ch, input logic [15:0] addr,
                                        input int words, input bit odd_tail);
        int          i;
        logic [15:0] w;
        queue_frame_head(ch, 8'(3 + 2 * words + int'(odd_tail)), CMD_WRITE);
        queue_byte(ch, addr[15:8]);
        queue_byte(ch, addr[7:0]);
        for (i = 0; i < words; i++)
        begin
            w = 16'($urandom_range(0, 16'hFFFF));
            queue_byte(ch, w[15:8]);
            queue_byte(ch, w[7:0]);
        end
        if (odd_tail)
            queue_byte(ch, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void queue_read(input logic ch, input logic [15:0] addr,
                                       input int count, input int extra);
        int i;
        queue_frame_head(ch, 8'(4 + extra), CMD_READ);
        queue_byte(ch, addr[15:8]);
        queue_byte(ch, addr[7:0]);
        queue_byte(ch, 8'(count));
        for (i = 0; i < extra; i++)
            queue_byte(ch, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void queue_random_frame(input logic ch);
        int          r;
        int          n;
        int          i;
        logic [7:0]  len;
        logic [7:0]  cmd;
        logic [15:0] addr;
        r = $urandom_range(0, 99);
        if (r < 38)
        begin
            n = ($urandom_range(0, 6) != 0) ? $urandom_range(0, 5) : $urandom_range(6, 24);
            queue_write(ch, pick_addr(), n, $urandom_range(0, 5) == 0);
        end
        else if (r < 75)
        begin
            i = $urandom_range(0, 99);
            n = (i < 75) ? $urandom_range(0, 8) :
                (i < 90) ? $urandom_range(9, MAX_READ_WORDS - 1) : MAX_READ_WORDS;
            queue_read(ch, pick_addr(), n,
                       ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0);
        end
        else if (r < 80)
            queue_read(ch, pick_addr(), $urandom_range(MAX_READ_WORDS + 1, 255), 0);
        else if (r < 85)
            queue_frame_head(ch, 8'($urandom_range(0, 2)),
                             $urandom_range(0, 1) ? CMD_READ : CMD_WRITE);
        else if (r < 88)
        begin
            // read without a count byte
            addr = pick_addr();
            queue_frame_head(ch, 8'd3, CMD_READ);
            queue_byte(ch, addr[15:8]);
            queue_byte(ch, addr[7:0]);
        end
        else if (r < 93)
        begin
            len = 8'($urandom_range(0, 255));
            cmd = 8'($urandom_range(0, 255));
            if (cmd == CMD_WRITE || cmd == CMD_READ)
                cmd = cmd ^ 8'h10;
            n = $urandom_range(0, 3);
            if (n == 0)
                cmd = HDR_HI;
            else if (n == 1)
            begin
                len = HDR_HI;
                cmd = HDR_LO;
            end
            queue_frame_head(ch, len, cmd);
        end
        else if (r < 96)
        begin
            queue_byte(ch, HDR_HI);
            if ($urandom_range(0, 1))
                queue_read(ch, pick_addr(), $urandom_range(0, 4), 0);
            else
                queue_byte(ch, 8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
                queue_byte(ch, 8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_byte(input logic ch, input logic [7:0] b);
        int gap;
        rx_if.valid      <= 1'b1;
        rx_if.in_channel <= ch;
        rx_if.rx_byte    <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        predict_replies(ch, b);
        items_sent++;
        gap = send_gaps_on ? next_gap(1'b0) : 0;
        if (gap > 0)
        begin
            rx_if.valid      <= 1'b0;
            rx_if.in_channel <= 1'($urandom_range(0, 1));
            rx_if.rx_byte    <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge clk);
        end
    endtask

    // Interleave whatever is queued on the two links
    task automatic send_queued();
        logic ch;
        while (ch0_bytes.size() != 0 || ch1_bytes.size() != 0)
        begin
            if (ch0_bytes.size() == 0)
                ch = 1'b1;
            else if (ch1_bytes.size() == 0)
                ch = 1'b0;
            else
                ch = 1'($urandom_range(0, 1));
            if (ch)
                send_byte(1'b1, ch1_bytes.pop_front());
            else
                send_byte(1'b0, ch0_bytes.pop_front());
        end
    endtask

    task automatic drain_replies();
        rx_if.valid <= 1'b0;
        while (reply_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_write_read_wrap();
        // second word lands at 0000 once the address counter wraps at 16 bits
        queue_write(1'b0, 16'hFFFF, 2, 1'b0);
        send_queued();
        // read straddles the top of the store and comes back from 000
        queue_read(1'b1, 16'h0FFF, 2, 0);
        send_queued();
        drain_replies();
    endtask

    task automatic test_header_rescan();
        // repeated 5A keeps waiting for A5, then a frame too short to use
        queue_byte(1'b1, HDR_HI);
        queue_frame_head(1'b1, 8'h02, CMD_WRITE);
        send_queued();
        drain_replies();
    endtask

    task automatic test_unknown_command();
        // 5A A5 5A A5 rescans into a fresh header, then a read with no count byte
        queue_byte(1'b0, HDR_HI);
        queue_byte(1'b0, HDR_LO);
        queue_frame_head(1'b0, 8'h03, CMD_READ);
        queue_byte(1'b0, 8'h00);
        queue_byte(1'b0, 8'h12);
        send_queued();
        drain_replies();
    endtask

    task automatic test_backpressure();
        int i;
        hold_request  <= 1'b1;
        send_gaps_on   = 1'b0;
        for (i = 0; i < 3; i++)
            queue_read(1'b0, pick_addr(), MAX_READ_WORDS, 0);
        queue_write(1'b1, pick_addr(), 4, 1'b0);
        send_queued();
        hold_request <= 1'b0;
        send_gaps_on  = 1'b1;
        drain_replies();
    endtask

    task automatic test_random_traffic();
        while (items_sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
                queue_random_frame(1'b0);
            if ($urandom_range(0, 9) < 7)
                queue_random_frame(1'b1);
            send_queued();
            if ($urandom_range(0, 19) == 0)
                drain_replies();
        end
        drain_replies();
    endtask

    // Reply side: check each accepted item, then pick the next ready level
    always @(posedge clk)
    begin : reply_sink
        reply_byte_t due;
        int          gap;
        if (rst_n)
        begin
            if (tx_if.valid && tx_if.ready)
            begin
                replies_checked++;
                if (reply_bytes_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: reply item with none expected: ch %0d byte %02h last %0b",
                             $time, tx_if.out_channel, tx_if.tx_byte, tx_if.last_of_reply);
                end
                else
                begin
                    due = reply_bytes_due.pop_front();
                    if (tx_if.out_channel !== due.ch)
                    begin
                        mismatches++;
                        $display("%0t: out_channel expected %0d, got %0d",
                                 $time, due.ch, tx_if.out_channel);
                    end
                    if (tx_if.tx_byte !== due.data)
                    begin
                        mismatches++;
                        $display("%0t: tx_byte expected %02h, got %02h",
                                 $time, due.data, tx_if.tx_byte);
                    end
                    if (tx_if.last_of_reply !== due.last)
                    begin
                        mismatches++;
                        $display("%0t: last_of_reply expected %0b, got %0b",
                                 $time, due.last, tx_if.last_of_reply);
                    end
                end
            end
            if (hold_request && !hold_seen)
                hold_left = HOLD_CYCLES;
            hold_seen = hold_request;
            if (hold_left > 0)
            begin
                hold_left--;
                tx_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                tx_if.ready <= 1'b0;
            end
            else
            begin
                gap = ($urandom_range(0, 3) == 0) ? next_gap(1'b1) : 0;
                if (gap == 0)
                    tx_if.ready <= 1'b1;
                else
                begin
                    tx_if.ready <= 1'b0;
                    stall_left = gap - 1;
                end
            end
        end
        else
        begin
            tx_if.ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rx_if.valid      = 1'b0;
        rx_if.in_channel = 1'b0;
        rx_if.rx_byte    = 8'h00;
        reset_frame_tracker();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_write_read_wrap();
        test_header_rescan();
        test_unknown_command();
        test_backpressure();
        test_random_traffic();

        $display("Sent %0d received items on both links, checked %0d reply items.",
                 items_sent, replies_checked);
        $display("Frames: %0d write acks, %0d read replies, %0d short or oversize dropped.",
                 acks_due, reads_due, frames_dropped);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
design/sfvms_pkg.sv
design/sfvms_if.sv
design/sfvms_ctrl.sv
design/sfvms_dp.sv
design/serial_frame_variable_memory_server.sv
dv/tb_serial_frame_variable_memory_server.sv
